/* hdl/ssf_pkg.sv */
`default_nettype none

package ssf_pkg;

   // Command opcodes
   localparam logic [1:0] OP_BLANK  = 2'd0;
   localparam logic [1:0] OP_NUMBER = 2'd1;
   localparam logic [1:0] OP_TEXT   = 2'd2;

   // Frame layout: start bit, four 8-bit digit patterns, three trailing zeros
   localparam int FRAME_BITS = 36;
   localparam int DIGITS     = 4;
   localparam int CNT_W      = $clog2(FRAME_BITS);

   // Digit codes: 0..9 are decimal digits, then blank and dash
   localparam logic [3:0] CODE_BLANK = 4'd10;
   localparam logic [3:0] CODE_DASH  = 4'd11;
   localparam int         NUM_CODES  = 12;

   // Segment patterns a..g in bits 7..1, bit 0 unused
   localparam logic [7:0] DIGIT_PAT [NUM_CODES] = '{
      8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6,
      8'hBE, 8'hE0, 8'hFE, 8'hF6, 8'h00, 8'h02
   };

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [15:0] number;
      logic [2:0]         dp_position;
      logic [7:0]         first_char;
      logic [7:0]         second_char;
      logic [7:0]         third_char;
      logic [7:0]         fourth_char;
   } req_type;

   typedef struct packed {
      logic serial_bit;
      logic last_bit;
   } rsp_type;

   // Per-digit description between the split and frame stages; index 0 is leftmost
   typedef struct packed {
      logic                  is_text;
      logic [DIGITS-1:0][3:0] code;
      logic [DIGITS-1:0][7:0] chars;
      logic [DIGITS-1:0]      dp;
   } glyph_type;

   typedef logic [FRAME_BITS-1:0] frame_type;

   // Segment pattern of a digit code; unused codes show blank
   function automatic logic [7:0] digit_segs(input logic [3:0] code);
      logic [7:0] pat;
      if (code < 4'(NUM_CODES)) begin
         pat = DIGIT_PAT[code];
      end else begin
         pat = DIGIT_PAT[CODE_BLANK];
      end
      return pat;
   endfunction

   // Character lookup: {known, pattern}; unknown characters show blank
   function automatic logic [8:0] char_lookup(input logic [7:0] c);
      logic [8:0] res;
      res = {1'b0, DIGIT_PAT[CODE_BLANK]};
      case (c)
         " ":     res = {1'b1, DIGIT_PAT[CODE_BLANK]};
         "-":     res = {1'b1, DIGIT_PAT[CODE_DASH]};
         "A":     res = {1'b1, 8'hEE};
         "C":     res = {1'b1, 8'h9C};
         "E":     res = {1'b1, 8'h9E};
         "H":     res = {1'b1, 8'h6E};
         "L":     res = {1'b1, 8'h1C};
         "P":     res = {1'b1, 8'hCE};
         "U":     res = {1'b1, 8'h7C};
         "d":     res = {1'b1, 8'hC6};
         "q":     res = {1'b1, 8'hE6};
         default: begin
            if (c >= "0" && c <= "9") begin
               res = {1'b1, digit_segs(c[3:0])};
            end
         end
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

/* hdl/ssf_digit_split.sv */
`default_nettype none

module ssf_digit_split
   import ssf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      leading_zeros,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire req_type   in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output glyph_type      out_data
);

   logic      valid_ff;
   glyph_type glyph_ff;
   glyph_type glyph_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = glyph_ff;

   // Number to digit codes, then opcode selection
   always_comb begin
      logic signed [15:0]     value;
      logic [15:0]            abs_value;
      logic                   in_range;
      logic                   neg;
      logic [13:0]            mag;
      logic [13:0]            r3;
      logic [9:0]             r2;
      logic [6:0]             r1;
      logic [3:0]             d3, d2, d1, d0;
      logic [3:0]             pad;
      logic [DIGITS-1:0][3:0] code;
      logic [DIGITS-1:0]      dp_sel;

      value     = in_data.number;
      in_range  = (value >= -16'sd999) && (value <= 16'sd9999);
      neg       = value[15];
      abs_value = neg ? 16'(-value) : 16'(value);
      mag       = abs_value[13:0];

      // thousands
      d3 = 4'd0;
      r3 = mag;
      for (int k = 1; k <= 9; k++) begin
         if (mag >= 14'(k * 1000)) begin
            d3 = 4'(k);
            r3 = mag - 14'(k * 1000);
         end
      end
      // hundreds
      d2 = 4'd0;
      r2 = r3[9:0];
      for (int k = 1; k <= 9; k++) begin
         if (r3[9:0] >= 10'(k * 100)) begin
            d2 = 4'(k);
            r2 = r3[9:0] - 10'(k * 100);
         end
      end
      // tens and ones
      d1 = 4'd0;
      r1 = r2[6:0];
      for (int k = 1; k <= 9; k++) begin
         if (r2[6:0] >= 7'(k * 10)) begin
            d1 = 4'(k);
            r1 = r2[6:0] - 7'(k * 10);
         end
      end
      d0 = r1[3:0];

      // sign and padding placement
      pad  = leading_zeros ? 4'd0 : CODE_BLANK;
      code = {d0, d1, d2, d3};
      if (mag <= 14'd999) begin
         code[0] = neg ? CODE_DASH : pad;
         if (mag <= 14'd99) begin
            if (!neg) begin
               code[1] = pad;
            end else if (leading_zeros) begin
               code[0] = CODE_DASH;
               code[1] = 4'd0;
            end else begin
               code[0] = CODE_BLANK;
               code[1] = CODE_DASH;
            end
            if (mag <= 14'd9) begin
               if (!neg) begin
                  code[2] = pad;
               end else if (leading_zeros) begin
                  code[2] = 4'd0;
               end else begin
                  code[1] = CODE_BLANK;
                  code[2] = CODE_DASH;
               end
            end
         end
      end

      for (int i = 0; i < DIGITS; i++) begin
         dp_sel[i] = (in_data.dp_position == 3'(i + 1));
      end

      glyph_in.is_text  = 1'b0;
      glyph_in.code     = {DIGITS{CODE_BLANK}};
      glyph_in.chars    = {in_data.fourth_char, in_data.third_char,
                           in_data.second_char, in_data.first_char};
      glyph_in.dp       = '0;

      unique case (in_data.opcode)
         OP_NUMBER: begin
            if (in_range) begin
               glyph_in.code = code;
               glyph_in.dp   = dp_sel;
            end else begin
               glyph_in.code = {DIGITS{CODE_DASH}};
            end
         end
         OP_TEXT: begin
            glyph_in.is_text = 1'b1;
            glyph_in.dp      = dp_sel;
         end
         default: begin
            // blank display, also for the unused opcode
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         glyph_ff <= glyph_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/ssf_frame_build.sv */
`default_nettype none

module ssf_frame_build
   import ssf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire glyph_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output frame_type      out_data
);

   logic      valid_ff;
   frame_type frame_ff;
   frame_type frame_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = frame_ff;

   // Segment lookup per digit and frame assembly, MSB goes out first
   always_comb begin
      logic [8:0] lookup;
      logic [7:0] digit_byte;

      frame_in             = '0;
      frame_in[FRAME_BITS-1] = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
         if (in_data.is_text) begin
            lookup = char_lookup(in_data.chars[i]);
         end else begin
            lookup = {1'b1, digit_segs(in_data.code[i])};
         end
         // unknown characters never light their decimal point
         digit_byte = {lookup[7:1], in_data.dp[i] & lookup[8]};
         frame_in[FRAME_BITS-2-8*i -: 8] = digit_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         frame_ff <= frame_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/ssf_shifter.sv */
`default_nettype none

module ssf_shifter
   import ssf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   output logic           in_ready,
   input  wire frame_type in_data,
   output logic           out_valid,
   input  wire logic      out_ready,
   output rsp_type        out_data
);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   frame_type        frame_ff;
   logic             last;
   logic             xfer;

   assign last      = (cnt_ff == CNT_W'(FRAME_BITS - 1));
   assign xfer      = busy_ff && out_ready;
   assign in_ready  = !busy_ff || (xfer && last);
   assign out_valid = busy_ff;
   assign out_data  = '{serial_bit: frame_ff[FRAME_BITS-1], last_bit: last};

   // Bit counter and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (in_valid && in_ready) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (xfer) begin
         if (last) begin
            busy_ff <= 1'b0;
         end
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // Load a new frame or shift one bit per transfer
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         frame_ff <= in_data;
      end else if (xfer) begin
         frame_ff <= {frame_ff[FRAME_BITS-2:0], 1'b0};
      end
   end

endmodule

`default_nettype wire

/* hdl/seven_segment_serial_formatter.sv */
`default_nettype none

// Four-digit seven-segment frame formatter. Each command (blank, signed
// number or four characters) becomes one 36-bit serial frame delivered as
// 36 rsp transfers, one bit each: a start 1, four digit patterns leftmost first
// (segments a..g then decimal point), and three 0 bits, with last_bit set on
// the final one. The output shifter sends one bit per cycle while rsp_ready
// is high, taking a new frame as the last bit of the current one transfers;
// a waiting frame's first bit follows in the next cycle. A command passes
// the input, split, frame and shifter registers in order; the input, split
// and frame registers hold up to three further commands while a frame
// shifts. csr_wdata sets leading-zero padding for numbers (reset value 0).

module seven_segment_serial_formatter
   import ssf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload,
   input  wire logic    csr_we,
   input  wire logic    csr_wdata
);

   logic      lz_ff;
   logic      req_valid_ff;
   req_type   req_data_ff;
   logic      split_ready;
   logic      glyph_valid;
   glyph_type glyph_data;
   logic      frame_ready;
   logic      frame_valid;
   frame_type frame_data;
   logic      shift_ready;

   // Leading-zero register
   always_ff @(posedge clock) begin
      if (reset) begin
         lz_ff <= 1'b0;
      end else if (csr_we) begin
         lz_ff <= csr_wdata;
      end
   end

   // Input register
   assign req_ready = !req_valid_ff || split_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_payload;
      end
   end

   ssf_digit_split u_split (
      .clock         (clock),
      .reset         (reset),
      .leading_zeros (lz_ff),
      .in_valid      (req_valid_ff),
      .in_ready      (split_ready),
      .in_data       (req_data_ff),
      .out_valid     (glyph_valid),
      .out_ready     (frame_ready),
      .out_data      (glyph_data)
   );

   ssf_frame_build u_frame (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (glyph_valid),
      .in_ready  (frame_ready),
      .in_data   (glyph_data),
      .out_valid (frame_valid),
      .out_ready (shift_ready),
      .out_data  (frame_data)
   );

   ssf_shifter u_shift (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (frame_valid),
      .in_ready  (shift_ready),
      .in_data   (frame_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_payload)
   );

   // A frame never breaks off before its last bit
   a_frame_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_payload.last_bit) |=> rsp_valid)
      else $error("frame ended before its last bit");

   // The final bit is a trailing zero
   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.last_bit) |-> !rsp_payload.serial_bit)
      else $error("last bit of frame is not zero");

   // A waiting frame starts right after the last bit, with its start bit
   a_next_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_payload.last_bit && frame_valid) |=>
      (rsp_valid && rsp_payload.serial_bit && !rsp_payload.last_bit))
      else $error("next frame did not start with its start bit");

endmodule

`default_nettype wire
